// File: rtl/tdscan_pkg.sv
// Shared types and constants for the template delimiter scanner.
package tdscan_pkg;

    localparam logic [7:0] CH_OPEN  = 8'h7B;
    localparam logic [7:0] CH_CLOSE = 8'h7D;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_BSL   = 8'h5C;

    localparam int unsigned MAX_RESULTS = 3;

    typedef enum logic [3:0] {
        MODE_TEXT    = 4'b0001,
        MODE_SCRIPT  = 4'b0010,
        MODE_ECHO    = 4'b0100,
        MODE_COMMENT = 4'b1000
    } mode_t;

    typedef enum logic [2:0] {
        KIND_TEXT   = 3'd0,
        KIND_SCRIPT = 3'd1,
        KIND_ECHO   = 3'd2,
        KIND_SEND   = 3'd3,
        KIND_EEND   = 3'd4,
        KIND_STREAM = 3'd5
    } kind_t;

    typedef struct packed {
        logic [7:0] ch;
        kind_t      kind;
    } result_t;

    // Results caused by one input byte, in order, plus how many are valid.
    typedef struct packed {
        logic [1:0]                  count;
        result_t [MAX_RESULTS-1:0]   items;
    } bundle_t;

    // Character that a mode holds for lookahead.
    function automatic logic [7:0] held_char(mode_t m);
        logic [7:0] ch;
        case (m)
            MODE_TEXT:    ch = CH_OPEN;
            MODE_SCRIPT:  ch = CH_CLOSE;
            MODE_ECHO:    ch = CH_EQ;
            MODE_COMMENT: ch = CH_HASH;
            default:      ch = CH_OPEN;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/tdscan_core.sv
// Delimiter scan logic: mode and lookahead state, results for one byte.
module tdscan_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                accept,
    input  logic [7:0]          in_char,
    input  logic                is_final,
    output tdscan_pkg::bundle_t bundle
);
    import tdscan_pkg::*;

    mode_t   mode_reg, mode_next;
    logic    held_reg, held_next;
    logic    do_fresh;
    logic    [7:0] hc;
    bundle_t b;

    function automatic bundle_t push(bundle_t bi, logic [7:0] ch, kind_t k);
        bundle_t r;
        r = bi;
        if (bi.count != 2'd3) begin
            r.items[bi.count].ch   = ch;
            r.items[bi.count].kind = k;
            r.count                = bi.count + 2'd1;
        end
        return r;
    endfunction

    // Emit a byte of the given mode; comment mode drops it.
    function automatic bundle_t push_mode(bundle_t bi, logic [7:0] ch, mode_t m);
        bundle_t r;
        r = bi;
        case (m)
            MODE_TEXT:   r = push(bi, ch, KIND_TEXT);
            MODE_SCRIPT: r = push(bi, ch, KIND_SCRIPT);
            MODE_ECHO:   r = push(bi, ch, KIND_ECHO);
            default:     r = bi;
        endcase
        return r;
    endfunction

    always_comb begin
        mode_next = mode_reg;
        held_next = held_reg;
        b         = '0;
        hc        = held_char(mode_reg);
        do_fresh  = !held_reg;

        if (held_reg) begin
            held_next = 1'b0;
            if (mode_reg == MODE_TEXT && in_char == CH_OPEN) begin
                mode_next = MODE_SCRIPT;
            end else if (mode_reg == MODE_TEXT && in_char == CH_EQ) begin
                mode_next = MODE_ECHO;
            end else if (mode_reg == MODE_TEXT && in_char == CH_HASH) begin
                mode_next = MODE_COMMENT;
            end else if (mode_reg != MODE_TEXT && in_char == CH_CLOSE) begin
                if (mode_reg == MODE_SCRIPT) begin
                    b = push(b, 8'h00, KIND_SEND);
                end else if (mode_reg == MODE_ECHO) begin
                    b = push(b, 8'h00, KIND_EEND);
                end
                mode_next = MODE_TEXT;
            end else begin
                // Release the held character; a backslash is consumed here.
                b        = push_mode(b, hc, mode_reg);
                do_fresh = (in_char != CH_BSL);
            end
        end

        if (do_fresh) begin
            if (in_char == hc) begin
                held_next = 1'b1;
            end else begin
                b = push_mode(b, in_char, mode_reg);
            end
        end

        if (is_final) begin
            if (held_next) begin
                b = push_mode(b, held_char(mode_next), mode_next);
            end
            b         = push(b, 8'h00, KIND_STREAM);
            mode_next = MODE_TEXT;
            held_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_TEXT;
            held_reg <= 1'b0;
        end else if (accept) begin
            mode_reg <= mode_next;
            held_reg <= held_next;
        end
    end

    assign bundle = b;

endmodule

// File: rtl/tdscan_out.sv
// Result register: holds one byte's results and hands them out one per cycle while m_ready is high.
module tdscan_out (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,
    input  tdscan_pkg::bundle_t bundle,
    output logic                free,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [7:0]          m_out_char,
    output logic [2:0]          m_kind,
    output logic                m_run_last
);
    import tdscan_pkg::*;

    bundle_t    bundle_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       last;
    logic [1:0] last_idx;
    result_t    cur;

    assign last_idx = bundle_reg.count - 2'd1;
    assign last     = (idx_reg == last_idx);
    assign cur      = bundle_reg.items[idx_reg];

    // Free when empty, or when the final result leaves this cycle.
    assign free = !valid_reg || (m_ready && last);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (load && bundle.count != 2'd0) begin
            valid_reg <= 1'b1;
            idx_reg   <= 2'd0;
        end else if (valid_reg && m_ready) begin
            if (last) begin
                valid_reg <= 1'b0;
            end else begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load && bundle.count != 2'd0) begin
            bundle_reg <= bundle;
        end
    end

    assign m_valid    = valid_reg;
    assign m_out_char = cur.ch;
    assign m_kind     = cur.kind;
    assign m_run_last = last;

endmodule

// File: rtl/template_delimiter_scanner.sv
// Latency: first result of a byte appears the cycle after its transfer.
// Throughput: one byte per cycle while each byte yields at most one result and m_ready is high;
// a byte that yields several results holds the input until the result register hands out its last one.
// Bytes yielding no result are taken without loading the result register and present nothing.
// Reset (aresetn low, synchronous): text mode, nothing held, result register empty.
module template_delimiter_scanner (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_in_char,
    input  logic       s_is_final,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic [2:0] m_kind,
    output logic       m_run_last
);
    import tdscan_pkg::*;

    bundle_t bundle;
    logic    free;
    logic    accept;

    assign s_ready = free;
    assign accept  = s_valid && free;

    tdscan_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .in_char  (s_in_char),
        .is_final (s_is_final),
        .bundle   (bundle)
    );

    tdscan_out u_out (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (accept),
        .bundle     (bundle),
        .free       (free),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_kind     (m_kind),
        .m_run_last (m_run_last)
    );

endmodule

// File: verif/template_delimiter_scanner_tb.sv
// Self-checking testbench for the template delimiter scanner.
`timescale 1ns / 1ps

module template_delimiter_scanner_tb;
    import tdscan_pkg::*;

    localparam int unsigned RAND_ITEMS  = 500;
    localparam int unsigned CALM_ITEMS  = 70;
    localparam int unsigned HOLD_CYCLES = 120;
    localparam int unsigned LIMIT       = 200000;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic       typed;
        logic [7:0] exp_ch;
        kind_t      exp_kind;
    } row_t;

    typedef struct packed {
        logic [7:0] ch;
        kind_t      kind;
        logic       last;
    } token_t;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_in_char;
    logic       s_is_final;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_out_char;
    logic [2:0] m_kind;
    logic       m_run_last;

    // Scanner state as the checker tracks it.
    mode_t      scan_mode;
    logic       delim_held;

    row_t        byte_q[$];
    token_t      run_buf[$];
    token_t      want_q[$];
    int unsigned mismatch_count;
    int unsigned cycle_count;
    int unsigned gap_odds;
    int unsigned stall_odds;
    logic        calm;
    logic        hold_req;

    template_delimiter_scanner u_top (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_in_char  (s_in_char),
        .s_is_final (s_is_final),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_char (m_out_char),
        .m_kind     (m_kind),
        .m_run_last (m_run_last)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Character that each mode holds back while it waits for the next byte.
    function automatic logic [7:0] lookahead_char(input mode_t m);
        case (m)
            MODE_SCRIPT:  return CH_CLOSE;
            MODE_ECHO:    return CH_EQ;
            MODE_COMMENT: return CH_HASH;
            default:      return CH_OPEN;
        endcase
    endfunction

    function automatic void push_token(input logic [7:0] c, input kind_t k);
        token_t tok;
        tok.ch   = c;
        tok.kind = k;
        tok.last = 1'b0;
        run_buf.push_back(tok);
    endfunction

    // Drop in comment mode, otherwise tag with the kind of the current mode.
    function automatic void emit_in_mode(input logic [7:0] c);
        case (scan_mode)
            MODE_TEXT:   push_token(c, KIND_TEXT);
            MODE_SCRIPT: push_token(c, KIND_SCRIPT);
            MODE_ECHO:   push_token(c, KIND_ECHO);
            default:     ;
        endcase
    endfunction

    function automatic void scan_fresh(input logic [7:0] c);
        if (c == lookahead_char(scan_mode))
            delim_held = 1'b1;
        else
            emit_in_mode(c);
    endfunction

    // Advance the scanner by one byte; leaves its output tokens in run_buf.
    function automatic void scan_byte(input logic [7:0] c, input logic fin);
        logic [7:0] h;
        logic       taken;
        run_buf.delete();
        if (delim_held) begin
            h          = lookahead_char(scan_mode);
            delim_held = 1'b0;
            taken      = 1'b0;
            if (scan_mode == MODE_TEXT) begin
                taken = 1'b1;
                case (c)
                    CH_OPEN: scan_mode = MODE_SCRIPT;
                    CH_EQ:   scan_mode = MODE_ECHO;
                    CH_HASH: scan_mode = MODE_COMMENT;
                    default: taken = 1'b0;
                endcase
            end else if (c == CH_CLOSE) begin
                if (scan_mode == MODE_SCRIPT)
                    push_token(8'h00, KIND_SEND);
                else if (scan_mode == MODE_ECHO)
                    push_token(8'h00, KIND_EEND);
                scan_mode = MODE_TEXT;
                taken     = 1'b1;
            end
            if (!taken) begin
                emit_in_mode(h);
                // backslash escapes the held character and is itself dropped
                if (c != CH_BSL)
                    scan_fresh(c);
            end
        end else begin
            scan_fresh(c);
        end
        if (fin) begin
            if (delim_held)
                emit_in_mode(lookahead_char(scan_mode));
            push_token(8'h00, KIND_STREAM);
            scan_mode  = MODE_TEXT;
            delim_held = 1'b0;
        end
        if (run_buf.size() != 0)
            run_buf[run_buf.size() - 1].last = 1'b1;
    endfunction

    function automatic void put_row(input logic [7:0] c, input logic fin,
                                    input logic typed = 1'b0,
                                    input logic [7:0] ech = 8'h00,
                                    input kind_t ek = KIND_TEXT);
        row_t r;
        r.ch       = c;
        r.fin      = fin;
        r.typed    = typed;
        r.exp_ch   = ech;
        r.exp_kind = ek;
        byte_q.push_back(r);
    endfunction

    // Delimiter characters mixed with arbitrary bytes, which make up most draws.
    function automatic logic [7:0] body_byte();
        case ($urandom_range(0, 11))
            0:       return CH_OPEN;
            1:       return CH_CLOSE;
            2:       return CH_EQ;
            3:       return CH_HASH;
            4:       return CH_BSL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void build_template();
        logic [7:0] closer;
        repeat ($urandom_range(1, 6)) begin
            case ($urandom_range(0, 9))
                0, 1, 2: repeat ($urandom_range(1, 6)) put_row(body_byte(), 1'b0);
                3, 4, 5, 6, 7: begin
                    put_row(CH_OPEN, 1'b0);
                    case ($urandom_range(0, 2))
                        0:       closer = CH_CLOSE;
                        1:       closer = CH_EQ;
                        default: closer = CH_HASH;
                    endcase
                    // a script opens with a doubled brace
                    put_row(closer == CH_CLOSE ? CH_OPEN : closer, 1'b0);
                    repeat ($urandom_range(0, 6)) put_row(body_byte(), 1'b0);
                    // leave some sections unclosed
                    if ($urandom_range(0, 7) != 0) begin
                        put_row(closer, 1'b0);
                        put_row(CH_CLOSE, 1'b0);
                    end
                end
                8: begin
                    put_row(body_byte(), 1'b0);
                    put_row(CH_BSL, 1'b0);
                end
                default: repeat ($urandom_range(1, 4))
                    put_row(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            endcase
        end
        put_row(body_byte(), 1'b1);
    endfunction

    task automatic offer_byte(input row_t r);
        token_t tok;
        if (!calm && gap_odds != 0 && $urandom_range(0, 2 * gap_odds) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge aclk);
        end
        s_valid    <= 1'b1;
        s_in_char  <= r.ch;
        s_is_final <= r.fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        scan_byte(r.ch, r.fin);
        if (r.typed) begin
            tok.ch   = r.exp_ch;
            tok.kind = r.exp_kind;
            tok.last = 1'b1;
            want_q.push_back(tok);
        end else begin
            foreach (run_buf[i]) want_q.push_back(run_buf[i]);
        end
    endtask

    // Sender: reset, directed table, then random templates.
    initial begin
        int unsigned rand_items;
        int unsigned tmpl;
        aresetn        <= 1'b0;
        s_valid        <= 1'b0;
        s_in_char      <= 8'h00;
        s_is_final     <= 1'b0;
        scan_mode      = MODE_TEXT;
        delim_held     = 1'b0;
        mismatch_count = 0;
        calm           = 1'b0;
        hold_req       = 1'b0;
        gap_odds       = 2;
        rand_items     = 0;
        tmpl           = 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        put_row(8'h41,    1'b0, 1'b1, 8'h41,    KIND_TEXT);
        put_row(8'h00,    1'b0, 1'b1, 8'h00,    KIND_TEXT);
        put_row(8'hFF,    1'b0, 1'b1, 8'hFF,    KIND_TEXT);
        put_row(CH_OPEN,  1'b0);
        put_row(CH_BSL,   1'b0, 1'b1, CH_OPEN,  KIND_TEXT);
        put_row(CH_OPEN,  1'b0);
        put_row(8'h78,    1'b0);
        put_row(CH_OPEN,  1'b0);
        put_row(CH_OPEN,  1'b0);
        put_row(8'h61,    1'b0);
        put_row(CH_CLOSE, 1'b0);
        put_row(CH_BSL,   1'b0, 1'b1, CH_CLOSE, KIND_SCRIPT);
        put_row(CH_CLOSE, 1'b0);
        put_row(CH_CLOSE, 1'b0, 1'b1, 8'h00,    KIND_SEND);
        put_row(CH_OPEN,  1'b0);
        put_row(CH_EQ,    1'b0);
        put_row(CH_EQ,    1'b0);
        put_row(8'h71,    1'b0);
        put_row(CH_EQ,    1'b0);
        put_row(CH_CLOSE, 1'b0, 1'b1, 8'h00,    KIND_EEND);
        put_row(CH_OPEN,  1'b0);
        put_row(CH_HASH,  1'b0);
        put_row(CH_HASH,  1'b0);
        put_row(CH_CLOSE, 1'b0);
        // unclosed script ending on a held brace: three results from one byte
        put_row(CH_OPEN,  1'b0);
        put_row(CH_OPEN,  1'b0);
        put_row(CH_CLOSE, 1'b0);
        put_row(8'h79,    1'b1);
        foreach (byte_q[i]) offer_byte(byte_q[i]);

        while (rand_items < RAND_ITEMS) begin
            byte_q.delete();
            build_template();
            gap_odds = $urandom_range(0, 3);
            if (tmpl == 4)
                hold_req = 1'b1;
            if (tmpl == 12) begin
                // let the result side drain completely
                s_valid <= 1'b0;
                while (want_q.size() != 0) @(posedge aclk);
                @(posedge aclk);
            end
            foreach (byte_q[i]) offer_byte(byte_q[i]);
            rand_items += byte_q.size();
            tmpl++;
            if (rand_items + CALM_ITEMS >= RAND_ITEMS)
                calm = 1'b1;
        end

        s_valid <= 1'b0;
        while (want_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // Receiver: random back-pressure bursts plus one long hold-off.
    initial begin
        m_ready    <= 1'b0;
        stall_odds = 1;
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && stall_odds != 0 && $urandom_range(0, 3 * stall_odds) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            if ($urandom_range(0, 63) == 0)
                stall_odds = $urandom_range(0, 2);
        end
    end

    // Compare every result transfer with the oldest expected token.
    always @(posedge aclk) begin : result_check
        token_t w;
        if (aresetn && m_valid && m_ready) begin
            if (want_q.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected result: expected none, actual ch=%h kind=%0d last=%b",
                         $time, m_out_char, m_kind, m_run_last);
            end else begin
                w = want_q.pop_front();
                if (m_out_char !== w.ch) begin
                    mismatch_count++;
                    $display("%0t: out_char mismatch: expected %h, actual %h",
                             $time, w.ch, m_out_char);
                end
                if (m_kind !== w.kind) begin
                    mismatch_count++;
                    $display("%0t: kind mismatch: expected %0d, actual %0d",
                             $time, w.kind, m_kind);
                end
                if (m_run_last !== w.last) begin
                    mismatch_count++;
                    $display("%0t: run_last mismatch: expected %b, actual %b",
                             $time, w.last, m_run_last);
                end
            end
        end
    end

    initial cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule

// File: filelist.f
rtl/tdscan_pkg.sv
rtl/tdscan_core.sv
rtl/tdscan_out.sv
rtl/template_delimiter_scanner.sv
verif/template_delimiter_scanner_tb.sv
